>>> sv/rog_pkg.sv
`timescale 1ns / 1ps

package rog_pkg;

  localparam int unsigned ID_W    = 6;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned THR_W   = COORD_W + 1;
  localparam int unsigned DSQ_W   = 2 * THR_W;
  localparam int unsigned ROOT_W  = THR_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESH = 2'd1;

  localparam logic [ID_W-1:0]  TRACKED_ID_RST  = 6'd4;
  localparam logic [THR_W-1:0] JUMP_THRESH_RST = 17'd2143;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_COLLECTED = 3'd1,
    ST_CHOSEN    = 3'd2,
    ST_ACCEPTED  = 3'd3,
    ST_REJECTED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MUL_X   = 2'd0,
    MUL_Y   = 2'd1,
    MUL_Z   = 2'd2,
    MUL_THR = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec3_t;

  typedef struct packed {
    logic     cap_in;
    logic     store_we;
    logic     mem_rd;
    logic     row_ld;
    logic     sel_medoid;
    mul_sel_e mul_sel;
    logic     mul_en;
    logic     acc_load;
    logic     acc_add;
    logic     sqrt_start;
    logic     sum_clr;
    logic     sum_add;
    logic     best_ld;
    logic     ref_from_best;
    logic     ref_from_in;
    logic     out_ld;
    status_e  out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic id_match;
    logic below_thr;
    logic sum_lt_best;
    logic sqrt_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/rog_isqrt.sv
`timescale 1ns / 1ps

module rog_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rog_pkg::DSQ_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [rog_pkg::ROOT_W-1:0] root_o
);
  import rog_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 4;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [DSQ_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // one result bit per cycle, two radicand bits brought down each step
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[DSQ_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[DSQ_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> sv/rog_dp.sv
`timescale 1ns / 1ps

module rog_dp #(
  parameter int unsigned WARMUP_SAMPLES = 21,
  localparam int unsigned AW = $clog2(WARMUP_SAMPLES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rog_pkg::dp_cmd_t              cmd_i,
  input  logic [AW-1:0]                 mem_addr_i,
  output rog_pkg::dp_stat_t             stat_o,
  input  logic [rog_pkg::ID_W-1:0]      in_pose_id_i,
  input  rog_pkg::vec3_t                in_rot_i,
  input  rog_pkg::vec3_t                in_pos_i,
  input  logic                          cfg_we_i,
  input  logic [rog_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rog_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output rog_pkg::status_e              out_status_o,
  output rog_pkg::vec3_t                out_rot_o,
  output rog_pkg::vec3_t                out_pos_o
);
  import rog_pkg::*;

  localparam int unsigned SUM_W = ROOT_W + $clog2(WARMUP_SAMPLES);

  logic [ID_W-1:0]  tracked_q;
  logic [THR_W-1:0] thr_q;

  logic [ID_W-1:0] in_id_q;
  vec3_t           in_rot_q;
  vec3_t           in_pos_q;

  vec3_t mem_q [WARMUP_SAMPLES];
  vec3_t mem_rdata_q;
  vec3_t row_q;
  vec3_t best_row_q;
  vec3_t ref_q;

  vec3_t                     op_a;
  vec3_t                     op_b;
  logic signed [COORD_W-1:0] a_c;
  logic signed [COORD_W-1:0] b_c;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W-1:0]        mag;
  logic [THR_W-1:0]          mul_op;

  logic [DSQ_W-1:0]  prod_q;
  logic [DSQ_W-1:0]  acc_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  best_q;
  logic [ROOT_W-1:0] root;
  logic              sqrt_done;

  logic    out_valid_q;
  status_e out_status_q;
  vec3_t   out_rot_q;
  vec3_t   out_pos_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= TRACKED_ID_RST;
      thr_q     <= JUMP_THRESH_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_TRACKED_ID) begin
        tracked_q <= cfg_data_i[ID_W-1:0];
      end else if (cfg_index_i == CFG_JUMP_THRESH) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      mem_q[mem_addr_i] <= in_rot_q;
    end
    if (cmd_i.mem_rd) begin
      mem_rdata_q <= mem_q[mem_addr_i];
    end
  end

  // shared distance squarer
  always_comb begin
    op_a = cmd_i.sel_medoid ? row_q       : ref_q;
    op_b = cmd_i.sel_medoid ? mem_rdata_q : in_rot_q;
    case (cmd_i.mul_sel)
      MUL_Y: begin
        a_c = op_a.y;
        b_c = op_b.y;
      end
      MUL_Z: begin
        a_c = op_a.z;
        b_c = op_b.z;
      end
      default: begin
        a_c = op_a.x;
        b_c = op_b.x;
      end
    endcase
    diff   = {a_c[COORD_W-1], a_c} - {b_c[COORD_W-1], b_c};
    mag    = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
    mul_op = (cmd_i.mul_sel == MUL_THR) ? thr_q : {1'b0, mag};
  end

  rog_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (acc_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_id_q  <= in_pose_id_i;
      in_rot_q <= in_rot_i;
      in_pos_q <= in_pos_i;
    end
    if (cmd_i.row_ld) begin
      row_q <= mem_rdata_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= DSQ_W'(mul_op) * DSQ_W'(mul_op);
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + SUM_W'(root);
    end
    if (cmd_i.best_ld) begin
      best_q     <= sum_q;
      best_row_q <= row_q;
    end
  end

  // reference rotation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cmd_i.ref_from_best) begin
      ref_q <= best_row_q;
    end else if (cmd_i.ref_from_in) begin
      ref_q <= in_rot_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_status_q <= cmd_i.out_status;
      if (cmd_i.out_status == ST_ACCEPTED) begin
        out_rot_q <= in_rot_q;
        out_pos_q <= in_pos_q;
      end else begin
        out_rot_q <= '0;
        out_pos_q <= '0;
      end
    end
  end

  always_comb begin
    stat_o.id_match    = (in_id_q == tracked_q);
    stat_o.below_thr   = (acc_q < prod_q);
    stat_o.sum_lt_best = (sum_q < best_q);
    stat_o.sqrt_done   = sqrt_done;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_rot_o    = out_rot_q;
  assign out_pos_o    = out_pos_q;

endmodule

>>> sv/rog_ctrl.sv
`timescale 1ns / 1ps

module rog_ctrl #(
  parameter int unsigned WARMUP_SAMPLES = 21,
  localparam int unsigned AW = $clog2(WARMUP_SAMPLES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rog_pkg::dp_stat_t  stat_i,
  output rog_pkg::dp_cmd_t   cmd_o,
  output logic [AW-1:0]      mem_addr_o
);
  import rog_pkg::*;

  localparam int unsigned CNT_W = $clog2(WARMUP_SAMPLES + 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_G0,
    S_G1,
    S_G2,
    S_G3,
    S_G4,
    S_M_ROW,
    S_M_ROWW,
    S_M_COL,
    S_M_D0,
    S_M_D1,
    S_M_D2,
    S_M_D3,
    S_M_SQ,
    S_M_SQW,
    S_M_EVAL,
    S_M_DONE,
    S_FINISH
  } state_e;

  state_e         state_q;
  logic [CNT_W-1:0] count_q;
  logic           locked_q;
  logic [AW-1:0]  i_q;
  logic [AW-1:0]  j_q;
  status_e        status_q;

  logic count_lt;
  logic i_last;
  logic j_last;

  assign count_lt = (count_q < CNT_W'(WARMUP_SAMPLES));
  assign i_last   = (i_q == AW'(WARMUP_SAMPLES - 1));
  assign j_last   = (j_q == AW'(WARMUP_SAMPLES - 1));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_M_ROW: mem_addr_o = i_q;
      S_M_COL: mem_addr_o = j_q;
      default: mem_addr_o = count_q[AW-1:0];
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_X;
    cmd_o.out_status = status_q;
    case (state_q)
      S_IDLE:   cmd_o.cap_in = in_valid_i;
      S_CHECK:  cmd_o.store_we = stat_i.id_match && !locked_q && count_lt;
      S_G0: begin
        cmd_o.mul_sel = MUL_X;
        cmd_o.mul_en  = 1'b1;
      end
      S_G1: begin
        cmd_o.mul_sel  = MUL_Y;
        cmd_o.mul_en   = 1'b1;
        cmd_o.acc_load = 1'b1;
      end
      S_G2: begin
        cmd_o.mul_sel = MUL_Z;
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_add = 1'b1;
      end
      S_G3: begin
        cmd_o.mul_sel = MUL_THR;
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_add = 1'b1;
      end
      S_G4:     cmd_o.ref_from_in = stat_i.below_thr;
      S_M_ROW:  cmd_o.mem_rd = 1'b1;
      S_M_ROWW: begin
        cmd_o.row_ld  = 1'b1;
        cmd_o.sum_clr = 1'b1;
      end
      S_M_COL:  cmd_o.mem_rd = 1'b1;
      S_M_D0: begin
        cmd_o.mul_sel = MUL_X;
        cmd_o.mul_en  = 1'b1;
      end
      S_M_D1: begin
        cmd_o.mul_sel  = MUL_Y;
        cmd_o.mul_en   = 1'b1;
        cmd_o.acc_load = 1'b1;
      end
      S_M_D2: begin
        cmd_o.mul_sel = MUL_Z;
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_add = 1'b1;
      end
      S_M_D3:   cmd_o.acc_add = 1'b1;
      S_M_SQ:   cmd_o.sqrt_start = 1'b1;
      S_M_SQW:  cmd_o.sum_add = stat_i.sqrt_done;
      S_M_EVAL: cmd_o.best_ld = (i_q == '0) || stat_i.sum_lt_best;
      S_M_DONE: cmd_o.ref_from_best = 1'b1;
      S_FINISH: cmd_o.out_ld = stat_i.out_free;
      default:  ;
    endcase
    cmd_o.sel_medoid = state_q inside {S_M_D0, S_M_D1, S_M_D2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      locked_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      status_q <= ST_IGNORED;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!stat_i.id_match) begin
            status_q <= ST_IGNORED;
            state_q  <= S_FINISH;
          end else if (locked_q) begin
            state_q <= S_G0;
          end else if (count_lt) begin
            count_q  <= count_q + CNT_W'(1);
            status_q <= ST_COLLECTED;
            state_q  <= S_FINISH;
          end else begin
            i_q     <= '0;
            state_q <= S_M_ROW;
          end
        end
        S_G0: state_q <= S_G1;
        S_G1: state_q <= S_G2;
        S_G2: state_q <= S_G3;
        S_G3: state_q <= S_G4;
        S_G4: begin
          status_q <= stat_i.below_thr ? ST_ACCEPTED : ST_REJECTED;
          state_q  <= S_FINISH;
        end
        S_M_ROW:  state_q <= S_M_ROWW;
        S_M_ROWW: begin
          j_q     <= '0;
          state_q <= S_M_COL;
        end
        S_M_COL: state_q <= S_M_D0;
        S_M_D0:  state_q <= S_M_D1;
        S_M_D1:  state_q <= S_M_D2;
        S_M_D2:  state_q <= S_M_D3;
        S_M_D3:  state_q <= S_M_SQ;
        S_M_SQ:  state_q <= S_M_SQW;
        S_M_SQW: begin
          if (stat_i.sqrt_done) begin
            if (j_last) begin
              state_q <= S_M_EVAL;
            end else begin
              j_q     <= j_q + AW'(1);
              state_q <= S_M_COL;
            end
          end
        end
        S_M_EVAL: begin
          if (i_last) begin
            state_q <= S_M_DONE;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= S_M_ROW;
          end
        end
        S_M_DONE: begin
          locked_q <= 1'b1;
          status_q <= ST_CHOSEN;
          state_q  <= S_FINISH;
        end
        S_FINISH: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> stat_i.out_free)
    else $error("result word loaded over one not yet taken");

  a_store_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store_we |-> (!locked_q && count_q < CNT_W'(WARMUP_SAMPLES)))
    else $error("sample written after warm-up");

  a_locked_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock released without reset");

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.sqrt_done |-> (state_q == S_M_SQW))
    else $error("root finished outside its wait state");
`endif

endmodule

>>> sv/rotation_outlier_gate.sv
`timescale 1ns / 1ps

// Channel   Direction  Word                                   Handshake
// s_axis    in         tdata: pose_id, rot_x/y/z, pos_x/y/z    tvalid / tready
// m_axis    out        tuser: status; tdata: out_rot, out_pos  tvalid / tready
// cfg       in         cfg_index_i, cfg_data_i                 cfg_valid_i / cfg_ready_o
//
// Locked pose: the three squared differences and the squared threshold share one 17x17
//   squarer. Ignored and collected poses go from the ID check straight to the result.
// The word after warm-up runs the reference pick over all N*N sample pairs for
//   N = WARMUP_SAMPLES, with a 17-step root per pair.
// Reset clears control, configuration and the reference, not the sample memory.
// A waiting result does not block input; stall only when a new result would overwrite it.

module rotation_outlier_gate #(
  parameter int unsigned WARMUP_SAMPLES = 21
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [5:0] pose_id, [21:6] rot_x, [37:22] rot_y, [53:38] rot_z,
  // [69:54] pos_x, [85:70] pos_y, [101:86] pos_z, [103:102] zero
  input  logic [103:0]                        s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] out_rot_x, [31:16] out_rot_y, [47:32] out_rot_z,
  // [63:48] out_pos_x, [79:64] out_pos_y, [95:80] out_pos_z
  output logic [95:0]                         m_axis_tdata,
  // [2:0] status
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rog_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rog_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rog_pkg::*;

  localparam int unsigned AW = $clog2(WARMUP_SAMPLES);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] mem_addr;

  logic [ID_W-1:0] in_pose_id;
  vec3_t           in_rot;
  vec3_t           in_pos;
  status_e         out_status;
  vec3_t           out_rot;
  vec3_t           out_pos;

  // unpack the input word, first field lowest
  assign in_pose_id = s_axis_tdata[5:0];
  assign in_rot.x   = s_axis_tdata[21:6];
  assign in_rot.y   = s_axis_tdata[37:22];
  assign in_rot.z   = s_axis_tdata[53:38];
  assign in_pos.x   = s_axis_tdata[69:54];
  assign in_pos.y   = s_axis_tdata[85:70];
  assign in_pos.z   = s_axis_tdata[101:86];

  // registers are always writable while idle
  assign cfg_ready_o = 1'b1;

  rog_ctrl #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .mem_addr_o (mem_addr)
  );

  rog_dp #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mem_addr_i     (mem_addr),
    .stat_o         (stat),
    .in_pose_id_i   (in_pose_id),
    .in_rot_i       (in_rot),
    .in_pos_i       (in_pos),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (out_status),
    .out_rot_o      (out_rot),
    .out_pos_o      (out_pos)
  );

  // pack the result word
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {out_pos.z, out_pos.y, out_pos.x, out_rot.z, out_rot.y, out_rot.x};

endmodule
